@@ rtl/sti_pkg.sv @@
// Shared types and constants for the sorted table interpolating lookup.
// No dependencies; every other file of the block imports this package.
package sti_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned IdxW         = 8;
  localparam int unsigned CountW       = 9;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 9;
  localparam int unsigned DefaultDepth = 256;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    HIT_LOW     = 2'd0,
    HIT_HIGH    = 2'd1,
    HIT_EXACT   = 2'd2,
    HIT_BETWEEN = 2'd3
  } hit_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENTRY_COUNT = 1'b0,
    REG_INTERP_EN   = 1'b1
  } cfg_reg_e;

  // Input word
  typedef struct packed {
    cmd_e                     cmd;
    logic [IdxW-1:0]          entry_index;
    logic signed [DataW-1:0]  key;
    logic signed [DataW-1:0]  entry_value;
  } sti_in_t;

  // Result word
  typedef struct packed {
    logic signed [DataW-1:0]  result_value;
    hit_kind_e                hit_kind;
  } sti_out_t;

  // Classified operation held in the queue between front and back
  typedef struct packed {
    logic                     is_lookup;
    logic [IdxW-1:0]          index;
    logic signed [DataW-1:0]  key;
    logic signed [DataW-1:0]  value;
  } sti_op_t;

  // Live configuration
  typedef struct packed {
    logic [CountW-1:0]        entry_count;
    logic                     interp_en;
  } sti_cfg_t;

  // Operands of one interpolation
  typedef struct packed {
    logic signed [DataW-1:0]  x;
    logic signed [DataW-1:0]  x1;
    logic signed [DataW-1:0]  x2;
    logic signed [DataW-1:0]  y1;
    logic signed [DataW-1:0]  y2;
  } sti_span_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_MID,
    ST_ARITH,
    ST_EMIT
  } back_state_e;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL_LO,
    MD_MUL_HI,
    MD_SUM,
    MD_DIV,
    MD_FIN
  } md_state_e;

endpackage

@@ rtl/sti_front.sv @@
// Front end: accepts input words, drops writes beyond the table, queues the rest.
// Depends on sti_pkg.
module sti_front #(
  parameter int unsigned TABLE_DEPTH = sti_pkg::DefaultDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sti_pkg::sti_in_t in_data_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output sti_pkg::sti_op_t op_o
);
  import sti_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  sti_op_t         queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            accept, keep, push, pop;
  sti_op_t         new_op;

  // Classify the incoming word
  always_comb begin
    new_op.is_lookup = (in_data_i.cmd == CMD_LOOKUP);
    new_op.index     = in_data_i.entry_index;
    new_op.key       = in_data_i.key;
    new_op.value     = in_data_i.entry_value;
    keep = new_op.is_lookup || (32'(in_data_i.entry_index) < 32'(TABLE_DEPTH));
  end

  assign in_ready_o = (count_q != CntW'(QueueDepth));
  assign accept     = in_valid_i && in_ready_o;
  assign push       = accept && keep;
  assign op_valid_o = (count_q != '0);
  assign pop        = op_valid_o && op_ready_i;
  assign op_o       = queue_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  // Store queued words
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_op;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QueueDepth)
    else $error("queue count exceeds depth");

  a_drop_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !keep && !pop) |=> (count_q == $past(count_q)))
    else $error("out-of-range write entered the queue");
`endif

endmodule

@@ rtl/sti_muldiv.sv @@
// Interpolation unit: y1 + ((x-x1)*(y2-y1)) / (x2-x1), quotient toward zero.
// Two 33x16 partial products, then a restoring divide of one bit per cycle.
// Depends on sti_pkg.
module sti_muldiv (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  sti_pkg::sti_span_t               req_i,
  output logic                             done_o,
  output logic signed [sti_pkg::DataW-1:0] result_o
);
  import sti_pkg::*;

  localparam int unsigned DivSteps = DataW;
  localparam int unsigned StepW    = $clog2(DivSteps);
  localparam int unsigned HalfW    = DataW / 2;
  localparam int unsigned PpW      = DataW + 1 + HalfW;

  md_state_e          state_q, state_d;
  logic [StepW-1:0]   step_q;
  logic [DataW-1:0]   dx_q, span_q, rem_q, quo_q, y1_q;
  logic [DataW:0]     mag_q;
  logic               neg_q, span_zero_q;
  logic [PpW-1:0]     pp_lo_q, pp_hi_q;

  logic [DataW:0]     dx_full, span_full, dy_full;
  logic [2*DataW-1:0] prod;
  logic [DataW:0]     trial;
  logic               fits;

  // Operand differences at start
  always_comb begin
    dx_full   = {req_i.x[DataW-1], req_i.x} - {req_i.x1[DataW-1], req_i.x1};
    span_full = {req_i.x2[DataW-1], req_i.x2} - {req_i.x1[DataW-1], req_i.x1};
    dy_full   = {req_i.y2[DataW-1], req_i.y2} - {req_i.y1[DataW-1], req_i.y1};
  end

  // Combine partial products; product stays below 2^64 since dx < span
  assign prod  = (2*DataW)'(pp_lo_q) + ((2*DataW)'(pp_hi_q) << HalfW);
  assign trial = {rem_q, quo_q[DataW-1]};
  assign fits  = (trial >= {1'b0, span_q});

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MD_IDLE:   if (start_i) state_d = MD_MUL_LO;
      MD_MUL_LO: state_d = MD_MUL_HI;
      MD_MUL_HI: state_d = MD_SUM;
      MD_SUM:    state_d = MD_DIV;
      MD_DIV:    if (step_q == StepW'(DivSteps - 1)) state_d = MD_FIN;
      MD_FIN:    state_d = MD_IDLE;
      default:   state_d = MD_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done_o   = 1'b0;
    result_o = y1_q;
    unique case (state_q)
      MD_FIN: begin
        done_o = 1'b1;
        if (span_zero_q) begin
          result_o = y1_q;
        end else if (neg_q) begin
          result_o = y1_q - quo_q;
        end else begin
          result_o = y1_q + quo_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          dx_q        <= dx_full[DataW-1:0];
          span_q      <= span_full[DataW-1:0];
          span_zero_q <= (span_full == '0);
          neg_q       <= dy_full[DataW];
          mag_q       <= dy_full[DataW] ? -dy_full : dy_full;
          y1_q        <= req_i.y1;
        end
      end
      MD_MUL_LO: pp_lo_q <= mag_q * dx_q[HalfW-1:0];
      MD_MUL_HI: pp_hi_q <= mag_q * dx_q[DataW-1:HalfW];
      MD_SUM: begin
        rem_q  <= prod[2*DataW-1:DataW];
        quo_q  <= prod[DataW-1:0];
        step_q <= '0;
      end
      MD_DIV: begin
        rem_q  <= fits ? DataW'(trial - {1'b0, span_q}) : trial[DataW-1:0];
        quo_q  <= {quo_q[DataW-2:0], fits};
        step_q <= step_q + StepW'(1);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (state_q == MD_IDLE))
    else $error("interpolation started while busy");
`endif

endmodule

@@ rtl/sti_back.sv @@
// Back end: table memories, binary search sequencer and result register.
// Depends on sti_pkg and sti_muldiv.
module sti_back #(
  parameter int unsigned TABLE_DEPTH = sti_pkg::DefaultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  sti_pkg::sti_op_t  op_i,
  input  sti_pkg::sti_cfg_t cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sti_pkg::sti_out_t out_data_o
);
  import sti_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [DataW-1:0] bp_mem  [TABLE_DEPTH];
  logic [DataW-1:0] val_mem [TABLE_DEPTH];

  back_state_e             state_q, state_d;
  logic [AW-1:0]           lo_q, hi_q, mid_q, rd_addr, last_idx;
  logic signed [DataW-1:0] key_q, rd_bp_q, rd_val_q;
  logic signed [DataW-1:0] lo_bp_q, lo_val_q, hi_bp_q, hi_val_q, res_q;
  hit_kind_e               kind_q;
  logic                    out_valid_q;
  sti_out_t                out_q;

  logic [31:0]             count_ext, active;
  logic [AW:0]             sum_dn, sum_up;
  logic [AW-1:0]           mid_dn, mid_up;
  logic                    key_le, key_ge, key_lt, key_eq, brk, out_free, mem_we;
  logic                    md_start, md_done;
  logic signed [DataW-1:0] md_result;
  sti_span_t               md_req;

  // Last index in use: count of zero acts as one, large counts saturate
  always_comb begin
    count_ext = 32'(cfg_i.entry_count);
    if (count_ext == 32'd0) begin
      active = 32'd1;
    end else if (count_ext > 32'(TABLE_DEPTH)) begin
      active = 32'(TABLE_DEPTH);
    end else begin
      active = count_ext;
    end
    last_idx = AW'(active - 32'd1);
  end

  // Compare query with the entry just read; form the next midpoints
  always_comb begin
    key_le = (key_q <= rd_bp_q);
    key_ge = (key_q >= rd_bp_q);
    key_lt = (key_q < rd_bp_q);
    key_eq = (key_q == rd_bp_q);
    sum_dn = {1'b0, lo_q} + {1'b0, mid_q};
    sum_up = {1'b0, mid_q} + {1'b0, hi_q} + (AW+1)'(1);
    mid_dn = sum_dn[AW:1];
    mid_up = sum_up[AW:1];
    brk    = key_lt ? (lo_q == mid_dn) : (hi_q == mid_up);
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (op_valid_i && op_i.is_lookup) state_d = ST_FIRST;
      ST_FIRST: state_d = key_le ? ST_EMIT : ST_LAST;
      ST_LAST:  state_d = key_ge ? ST_EMIT : ST_MID;
      ST_MID: begin
        if (key_eq) begin
          state_d = ST_EMIT;
        end else if (brk) begin
          state_d = cfg_i.interp_en ? ST_ARITH : ST_EMIT;
        end
      end
      ST_ARITH: if (md_done) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs per state
  always_comb begin
    op_ready_o = 1'b0;
    mem_we     = 1'b0;
    md_start   = 1'b0;
    rd_addr    = mid_q;
    unique case (state_q)
      ST_IDLE: begin
        op_ready_o = 1'b1;
        mem_we     = op_valid_i && !op_i.is_lookup;
        rd_addr    = '0;
      end
      ST_FIRST: rd_addr = hi_q;
      ST_LAST:  rd_addr = hi_q >> 1;
      ST_MID: begin
        rd_addr  = key_lt ? mid_dn : mid_up;
        md_start = !key_eq && brk && cfg_i.interp_en;
      end
      default: ;
    endcase
  end

  // Interpolation operands: the bracket after this step's update
  always_comb begin
    md_req.x = key_q;
    if (key_lt) begin
      md_req.x1 = lo_bp_q;
      md_req.y1 = lo_val_q;
      md_req.x2 = rd_bp_q;
      md_req.y2 = rd_val_q;
    end else begin
      md_req.x1 = rd_bp_q;
      md_req.y1 = rd_val_q;
      md_req.x2 = hi_bp_q;
      md_req.y2 = hi_val_q;
    end
  end

  sti_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .req_i    (md_req),
    .done_o   (md_done),
    .result_o (md_result)
  );

  // Table memories with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bp_mem[AW'(op_i.index)]  <= op_i.key;
      val_mem[AW'(op_i.index)] <= op_i.value;
    end
    rd_bp_q  <= bp_mem[rd_addr];
    rd_val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search bracket and result
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (op_valid_i && op_i.is_lookup) begin
          key_q <= op_i.key;
          lo_q  <= '0;
          hi_q  <= last_idx;
        end
      end
      ST_FIRST: begin
        if (key_le) begin
          res_q  <= rd_val_q;
          kind_q <= HIT_LOW;
        end else begin
          lo_bp_q  <= rd_bp_q;
          lo_val_q <= rd_val_q;
        end
      end
      ST_LAST: begin
        if (key_ge) begin
          res_q  <= rd_val_q;
          kind_q <= HIT_HIGH;
        end else begin
          hi_bp_q  <= rd_bp_q;
          hi_val_q <= rd_val_q;
          mid_q    <= hi_q >> 1;
        end
      end
      ST_MID: begin
        if (key_eq) begin
          res_q  <= rd_val_q;
          kind_q <= HIT_EXACT;
        end else begin
          if (key_lt) begin
            hi_q     <= mid_q;
            hi_bp_q  <= rd_bp_q;
            hi_val_q <= rd_val_q;
            mid_q    <= mid_dn;
          end else begin
            lo_q     <= mid_q;
            lo_bp_q  <= rd_bp_q;
            lo_val_q <= rd_val_q;
            mid_q    <= mid_up;
          end
          if (brk) begin
            kind_q <= HIT_BETWEEN;
            res_q  <= key_lt ? lo_val_q : rd_val_q;
          end
        end
      end
      ST_ARITH: if (md_done) res_q <= md_result;
      ST_EMIT: begin
        if (out_free) begin
          out_q.result_value <= res_q;
          out_q.hit_kind     <= kind_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MID) |-> ((lo_q < hi_q) && (mid_q >= lo_q) && (mid_q < hi_q)))
    else $error("search bracket broken");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
    else $error("result shown without a finished lookup");
`endif

endmodule

@@ rtl/sorted_table_interp_lookup.sv @@
// Sorted breakpoint table lookup with optional linear interpolation, Q16.16.
// Writes: one per cycle while the 2-word queue has room, stored in the table as they leave the queue.
// Lookups: one at a time; a low clamp is settled by reading entry 0, a high clamp by reading the
// last active entry, any other key by the binary search, followed by the multiply and 32-step
// divide when interpolating; the next word waits meanwhile.
// Reset clears control and config (entry_count 1, interpolation off), not the table.
module sorted_table_interp_lookup #(
  parameter int unsigned TABLE_DEPTH = sti_pkg::DefaultDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sti_pkg::sti_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sti_pkg::sti_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [sti_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sti_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import sti_pkg::*;

  logic              op_valid, op_ready;
  sti_op_t           op;
  sti_cfg_t          cfg_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_count <= CountW'(1);
      cfg_q.interp_en   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ENTRY_COUNT: cfg_q.entry_count <= cfg_wdata_i[CountW-1:0];
        REG_INTERP_EN:   cfg_q.interp_en   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  sti_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  sti_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/sorted_table_interp_lookup_tb.sv @@
// Self-checking testbench for sorted_table_interp_lookup: table writes, lookups, both modes.
// Depends on sti_pkg and the block's RTL only; a scoreboard class predicts every result.
`timescale 1ns / 100ps

module sorted_table_interp_lookup_tb;
  import sti_pkg::*;

  localparam int SettleCycles  = 64;
  localparam int DrainLimit    = 50000;
  localparam int LimitNs       = 2_000_000;
  localparam int ItemsPerPhase = 42;
  localparam int HoldOffCycles = 600;
  localparam int NumPhases     = 12;
  localparam int MaxPrinted    = 40;

  // Predict lookup results from the words the block accepts, and check them
  class lookup_scoreboard;
    logic signed [DataW-1:0] breakpoints [DefaultDepth];
    logic signed [DataW-1:0] values [DefaultDepth];
    logic [CountW-1:0] entry_count = 1;
    bit interp_en = 1'b0;
    sti_out_t expected_results [$];
    int mismatches = 0;
    int writes_seen = 0;
    int kind_seen [4] = '{0, 0, 0, 0};

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    function void set_reg(cfg_reg_e which, logic [CfgDataW-1:0] data);
      if (which == REG_ENTRY_COUNT) entry_count = data;
      else interp_en = data[0];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Linear interpolation with a full-width product, quotient truncated toward zero
    function logic signed [DataW-1:0] interpolate_span(logic signed [DataW-1:0] x1,
                                                       logic signed [DataW-1:0] y1,
                                                       logic signed [DataW-1:0] x2,
                                                       logic signed [DataW-1:0] y2,
                                                       logic signed [DataW-1:0] x);
      longint unsigned dx, span, mag, quot;
      longint dy, sum;
      bit neg;
      dx = longint'(x) - longint'(x1);
      span = longint'(x2) - longint'(x1);
      dy = longint'(y2) - longint'(y1);
      neg = dy < 0;
      mag = neg ? -dy : dy;
      if (span == 0) return y1;
      quot = (dx * mag) / span;
      sum = longint'(y1) + (neg ? -longint'(quot) : longint'(quot));
      return sum[DataW-1:0];
    endfunction

    // Clamp at the ends, else run the fixed binary search over the active entries
    function sti_out_t predict_lookup(logic signed [DataW-1:0] x);
      sti_out_t res;
      int unsigned lo, hi, mid;
      bit done, exact;
      lo = 0;
      hi = (entry_count == 0) ? 0 : ((entry_count > DefaultDepth) ? DefaultDepth - 1
                                                                   : entry_count - 1);
      if (x <= breakpoints[0]) begin
        res.result_value = values[0];
        res.hit_kind = HIT_LOW;
      end else if (x >= breakpoints[hi]) begin
        res.result_value = values[hi];
        res.hit_kind = HIT_HIGH;
      end else begin
        mid = (lo + hi) / 2;
        done = 1'b0;
        exact = 1'b0;
        while (!done) begin
          if (x < breakpoints[mid]) begin
            hi = mid;
            mid = (lo + hi) / 2;
            done = (lo == mid);
          end else if (x > breakpoints[mid]) begin
            lo = mid;
            mid = (lo + hi + 1) / 2;
            done = (hi == mid);
          end else begin
            exact = 1'b1;
            done = 1'b1;
          end
        end
        if (exact) begin
          res.result_value = values[mid];
          res.hit_kind = HIT_EXACT;
        end else begin
          res.hit_kind = HIT_BETWEEN;
          if (interp_en)
            res.result_value = interpolate_span(breakpoints[lo], values[lo],
                                                breakpoints[hi], values[hi], x);
          else
            res.result_value = values[lo];
        end
      end
      return res;
    endfunction

    // Apply an accepted input word: store an entry or queue the lookup's result
    function void note_word(sti_in_t word);
      if (word.cmd == CMD_WRITE) begin
        breakpoints[word.entry_index] = word.key;
        values[word.entry_index] = word.entry_value;
        writes_seen++;
      end else begin
        expected_results.push_back(predict_lookup(word.key));
      end
    endfunction

    // Compare an accepted result word with the oldest prediction
    task check_result(sti_out_t got);
      sti_out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word value %h kind %0d",
                                  got.result_value, got.hit_kind));
      end else begin
        want = expected_results.pop_front();
        kind_seen[want.hit_kind]++;
        if (got.result_value !== want.result_value)
          report_mismatch($sformatf("result_value %h, expected %h (kind %0d)",
                                    got.result_value, want.result_value, want.hit_kind));
        if (got.hit_kind !== want.hit_kind)
          report_mismatch($sformatf("hit_kind %0d, expected %0d",
                                    got.hit_kind, want.hit_kind));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  sti_in_t                 in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  sti_out_t                out_data;
  logic                    cfg_we = 1'b0;
  cfg_reg_e                cfg_index = REG_ENTRY_COUNT;
  logic [CfgDataW-1:0]     cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;
  logic signed [DataW-1:0] issued_keys [DefaultDepth];

  lookup_scoreboard sb = new();

  sorted_table_interp_lookup dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Drive result ready: hold off while the counter runs, else stall at random
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_word(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(sti_in_t word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_entry(int unsigned idx, logic signed [DataW-1:0] k,
                            logic signed [DataW-1:0] v);
    sti_in_t word;
    word.cmd = CMD_WRITE;
    word.entry_index = IdxW'(idx);
    word.key = k;
    word.entry_value = v;
    issued_keys[idx] = k;
    send_word(word);
  endtask

  // Lookup word; index and value bits are don't-care, so randomize them
  task automatic send_lookup(logic signed [DataW-1:0] k);
    sti_in_t word;
    word.cmd = CMD_LOOKUP;
    word.entry_index = IdxW'($urandom_range(255));
    word.key = k;
    word.entry_value = $urandom;
    send_word(word);
  endtask

  // Write entries 0..count-1: ascending (mode 0), ascending with repeats (1), random (2)
  task automatic fill_table(int unsigned count, int mode);
    longint step_max, cur;
    int unsigned i;
    logic signed [DataW-1:0] bp;
    if (mode == 1) step_max = 3;
    else if ($urandom_range(3) == 0) step_max = 64;
    else step_max = 64'd4294967295 / (count + 1);
    cur = -64'sd2147483648 + longint'($urandom) % (64'd4294967296 - step_max * (count + 1));
    for (i = 0; i < count; i++) begin
      bp = (mode == 2) ? $urandom : cur[DataW-1:0];
      send_entry(i, bp, $urandom);
      cur += ((mode == 1) ? 0 : 1) + longint'($urandom) % step_max;
    end
  endtask

  task automatic write_reg(cfg_reg_e which, logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(which, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every predicted result, then let trailing writes land
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_count [NumPhases];
    int unsigned count, active, i, j, p, k;
    int mode;
    longint gap, pick;
    logic signed [DataW-1:0] key;

    phase_count = '{2, 3, 7, 16, 1, 0, 33, 256, 300, 511, 5, 64};
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;

    // Directed: extreme breakpoints and values, clamps, exact hits, wide spans
    write_reg(REG_ENTRY_COUNT, 9'd4);
    write_reg(REG_INTERP_EN, 9'd1);
    send_entry(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_entry(1, 32'shFFFF_0000, 32'sh8000_0000);
    send_entry(2, 32'sh0001_0000, 32'sh0000_0000);
    send_entry(3, 32'sh7FFF_FFFF, 32'sh1234_5678);
    send_lookup(32'sh8000_0000);
    send_lookup(32'sh7FFF_FFFF);
    send_lookup(32'shFFFF_0000);
    send_lookup(32'sh0001_0000);
    send_lookup(32'sh0000_0000);
    send_lookup(32'shC000_0000);
    send_lookup(32'sh8000_0001);
    send_lookup(32'sh7FFF_FFFE);
    drain_results();
    // Lower entry value instead of interpolation
    write_reg(REG_INTERP_EN, 9'd0);
    send_lookup(32'sh0000_0000);
    send_lookup(32'shC000_0000);
    drain_results();
    // Zero entry count behaves as a single entry
    write_reg(REG_ENTRY_COUNT, 9'd0);
    send_lookup(32'sh8000_0000);
    send_lookup(32'sh0000_0000);
    drain_results();
    write_reg(REG_ENTRY_COUNT, 9'd1);
    send_lookup(32'sh8000_0000);
    send_lookup(32'sh7FFF_FFFF);
    drain_results();

    // Random phases: fresh table per configuration, mostly lookups aimed at it
    for (p = 0; p < NumPhases; p++) begin
      count = phase_count[p];
      active = (count == 0) ? 1 : ((count > DefaultDepth) ? DefaultDepth : count);
      mode = (count == 16) ? 1 : ((count == 33 || count == 5) ? 2 : 0);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      write_reg(REG_ENTRY_COUNT, CfgDataW'(count));
      write_reg(REG_INTERP_EN, (p % 3 != 0) ? 9'd1 : 9'd0);
      // Saturated counts reuse the full table written by the phase before them
      if (count <= DefaultDepth) fill_table(active, mode);
      // Back up the output so the block fills and stalls its input
      if (p == 0) hold_off_left = HoldOffCycles;
      for (k = 0; k < ItemsPerPhase; k++) begin
        if ($urandom_range(99) < 10) begin
          send_entry($urandom_range(255), $urandom, $urandom);
        end else begin
          i = $urandom_range(active - 1);
          case ($urandom_range(9))
            0: key = issued_keys[i];
            1, 2, 3, 4, 5: begin
              if (active > 1) begin
                j = $urandom_range(active - 2);
                gap = longint'(issued_keys[j + 1]) - longint'(issued_keys[j]);
                pick = longint'(issued_keys[j]);
                if (gap > 1) pick = pick + 1 + longint'($urandom) % (gap - 1);
                key = pick[DataW-1:0];
              end else begin
                key = $urandom;
              end
            end
            6: key = issued_keys[0] - $urandom_range(3);
            7: key = issued_keys[active - 1] + $urandom_range(3);
            8: key = $urandom;
            default: key = issued_keys[i] + ($urandom_range(1) ? 1 : -1);
          endcase
          send_lookup(key);
        end
      end
      drain_results();
    end

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Checked %0d lookups (clamped low %0d, clamped high %0d, exact %0d, between %0d)",
             sb.kind_seen[0] + sb.kind_seen[1] + sb.kind_seen[2] + sb.kind_seen[3],
             sb.kind_seen[HIT_LOW], sb.kind_seen[HIT_HIGH], sb.kind_seen[HIT_EXACT],
             sb.kind_seen[HIT_BETWEEN]);
    $display("over %0d table writes and %0d register settings; %0d mismatches",
             sb.writes_seen, 2 * NumPhases + 5, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #(LimitNs);
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/sti_pkg.sv
rtl/sti_front.sv
rtl/sti_muldiv.sv
rtl/sti_back.sv
rtl/sorted_table_interp_lookup.sv
sim/sorted_table_interp_lookup_tb.sv
